// ===== rtl/mlcd_pkg.sv =====
package mlcd_pkg;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_CRCBAD  = 3'd3,
        KIND_BADLEN  = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_MAGIC  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MAGIC = 2'd1;

    localparam int unsigned INDEX_W = 11;
    localparam logic [7:0]  CRC_POLY = 8'h07;
    localparam logic [7:0]  CRC_INIT = 8'h00;

    // One result item
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [INDEX_W-1:0] index;
    } result_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/magic_length_crc8_deframer.sv =====
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+----------------------------------------
// s_       | in  | s_tvalid / s_tready    | s_tdata[7:0] in_byte
// m_       | out | m_tvalid / m_tready    | m_tdata: out_byte, body_index; m_tuser: out_kind
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 first, 1 second magic)
//
// One byte per cycle while s_tready is high; each byte is parsed in the cycle it is
// accepted and its result is registered into a two-entry output buffer.
// s_tready drops only when both output entries are full under a stalled m_tready.
// aresetn is synchronous, active low; it clears the parser, magic bytes and buffer.
// Configuration writes are always taken (cfg_ready is high).
module magic_length_crc8_deframer #(
    parameter int unsigned MAX_PAYLOAD = 1023
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [18:8] body_index, [23:19] zero
    output logic [2:0]  m_tuser,   // [2:0] out_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic              in_accept;
    logic              res_valid;
    mlcd_pkg::result_t res;
    mlcd_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid & s_tready;

    mlcd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    mlcd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept & res_valid),
        .push_res  (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result item
    assign m_tdata = {5'd0, out_res.index, out_res.data};
    assign m_tuser = out_res.kind;

endmodule

// ===== rtl/mlcd_core.sv =====
module mlcd_core #(
    parameter int unsigned MAX_PAYLOAD = 1023
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output mlcd_pkg::result_t    res
);

    localparam logic [16:0] LenLimit = 17'(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        PH_MAGIC1 = 3'd0,
        PH_MAGIC2 = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_BODY   = 3'd4,
        PH_CHECK  = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  first_magic_reg, second_magic_reg;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] len_word;
    logic [15:0] seen_inc;

    assign len_word = {length_high_reg, in_byte};
    assign seen_inc = bytes_seen_reg + 16'd1;

    // Frame parser: next state and the result for this byte
    always_comb begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        body_length_next = body_length_reg;
        bytes_seen_next  = bytes_seen_reg;
        crc_next         = crc_reg;
        res_valid        = 1'b0;
        res.kind         = mlcd_pkg::KIND_ID;
        res.data         = 8'd0;
        res.index        = '0;
        unique case (phase_reg)
            PH_MAGIC2: begin
                phase_next = (in_byte == second_magic_reg) ? PH_LENHI : PH_MAGIC1;
            end
            PH_LENHI: begin
                length_high_next = in_byte;
                phase_next       = PH_LENLO;
            end
            PH_LENLO: begin
                body_length_next = len_word;
                if (len_word == 16'd0 || {1'b0, len_word} > LenLimit) begin
                    phase_next = PH_MAGIC1;
                    res_valid  = 1'b1;
                    res.kind   = mlcd_pkg::KIND_BADLEN;
                end else begin
                    bytes_seen_next = 16'd0;
                    crc_next        = mlcd_pkg::CRC_INIT;
                    phase_next      = PH_BODY;
                end
            end
            PH_BODY: begin
                res_valid       = 1'b1;
                res.kind        = (bytes_seen_reg == 16'd0) ? mlcd_pkg::KIND_ID
                                                            : mlcd_pkg::KIND_PAYLOAD;
                res.data        = in_byte;
                res.index       = bytes_seen_reg[mlcd_pkg::INDEX_W-1:0];
                crc_next        = mlcd_pkg::crc8_byte(crc_reg, in_byte);
                bytes_seen_next = seen_inc;
                if (seen_inc >= body_length_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                phase_next = PH_MAGIC1;
                res_valid  = 1'b1;
                res.kind   = (in_byte == crc_reg) ? mlcd_pkg::KIND_GOOD
                                                  : mlcd_pkg::KIND_CRCBAD;
            end
            default: begin
                phase_next = (in_byte == first_magic_reg) ? PH_MAGIC2 : PH_MAGIC1;
            end
        endcase
    end

    // Parser state, updated on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_MAGIC1;
            length_high_reg <= 8'd0;
            body_length_reg <= 16'd0;
            bytes_seen_reg  <= 16'd0;
            crc_reg         <= 8'd0;
        end else if (in_accept) begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            body_length_reg <= body_length_next;
            bytes_seen_reg  <= bytes_seen_next;
            crc_reg         <= crc_next;
        end
    end

    // Magic byte registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_magic_reg  <= 8'd0;
            second_magic_reg <= 8'd0;
        end else if (cfg_we) begin
            if (cfg_index == mlcd_pkg::CFG_FIRST_MAGIC) begin
                first_magic_reg <= cfg_data;
            end
            if (cfg_index == mlcd_pkg::CFG_SECOND_MAGIC) begin
                second_magic_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/mlcd_outbuf.sv =====
module mlcd_outbuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mlcd_pkg::result_t    push_res,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mlcd_pkg::result_t    out_res
);

    logic              main_valid_reg, skid_valid_reg;
    mlcd_pkg::result_t main_reg, skid_reg;
    logic              pop;

    assign pop       = main_valid_reg & out_ready;
    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= push_res;
            end else begin
                main_reg <= push_res;
            end
        end
    end

endmodule

// ===== tb/magic_length_crc8_deframer_tb.sv =====
module magic_length_crc8_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BODY      = 1023;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 2000;

    // Parser phases of the local predictor
    typedef enum logic [2:0] {
        P_HUNT1  = 3'd0,
        P_HUNT2  = 3'd1,
        P_LEN_HI = 3'd2,
        P_LEN_LO = 3'd3,
        P_BODY   = 3'd4,
        P_CRC    = 3'd5
    } parse_phase_t;

    // Receiver backpressure patterns
    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_COIN     = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_SPARSE   = 2'd3
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = mlcd_pkg::CFG_FIRST_MAGIC;
    logic [7:0]  cfg_data  = 8'h00;

    magic_length_crc8_deframer #(
        .MAX_PAYLOAD(MAX_BODY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Bytes waiting to be sent, and results the predictor says must come out
    logic [7:0]          byte_q[$];
    mlcd_pkg::result_t   result_q[$];

    // Predictor state
    logic [7:0]   magic1 = 8'h00;
    logic [7:0]   magic2 = 8'h00;
    parse_phase_t parse_phase = P_HUNT1;
    logic [7:0]   len_hi = 8'h00;
    logic [15:0]  body_len = 16'h0000;
    logic [15:0]  body_seen = 16'h0000;
    logic [7:0]   body_crc = 8'h00;

    logic s_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int unsigned mismatches = 0;
    int unsigned bytes_pushed = 0;
    int unsigned items_in = 0;
    int unsigned body_bytes = 0;
    int unsigned frames_good = 0;
    int unsigned frames_crc_bad = 0;
    int unsigned frames_bad_len = 0;

    // CRC-8 poly 0x07, one input bit at a time, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? mlcd_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advance the predicted parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b);
        mlcd_pkg::result_t r;
        bit                has_result;
        has_result = 1'b0;
        r = '{kind: mlcd_pkg::KIND_ID, data: 8'h00, index: '0};
        case (parse_phase)
            P_HUNT2: begin
                parse_phase = (b == magic2) ? P_LEN_HI : P_HUNT1;
            end
            P_LEN_HI: begin
                len_hi = b;
                parse_phase = P_LEN_LO;
            end
            P_LEN_LO: begin
                body_len = {len_hi, b};
                if (body_len == 16'h0000 || body_len > MAX_BODY + 1) begin
                    r.kind = mlcd_pkg::KIND_BADLEN;
                    has_result = 1'b1;
                    frames_bad_len++;
                    parse_phase = P_HUNT1;
                end else begin
                    body_seen = 16'h0000;
                    body_crc = mlcd_pkg::CRC_INIT;
                    parse_phase = P_BODY;
                end
            end
            P_BODY: begin
                r.kind  = (body_seen == 16'h0000) ? mlcd_pkg::KIND_ID : mlcd_pkg::KIND_PAYLOAD;
                r.data  = b;
                r.index = body_seen[mlcd_pkg::INDEX_W-1:0];
                has_result = 1'b1;
                body_bytes++;
                body_crc = crc8_step(body_crc, b);
                body_seen = body_seen + 16'd1;
                if (body_seen >= body_len) begin
                    parse_phase = P_CRC;
                end
            end
            P_CRC: begin
                if (b == body_crc) begin
                    r.kind = mlcd_pkg::KIND_GOOD;
                    frames_good++;
                end else begin
                    r.kind = mlcd_pkg::KIND_CRCBAD;
                    frames_crc_bad++;
                end
                has_result = 1'b1;
                parse_phase = P_HUNT1;
            end
            default: begin
                parse_phase = (b == magic1) ? P_HUNT2 : P_HUNT1;
            end
        endcase
        if (has_result) begin
            result_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Monitor: track accepted items, predict, and check results
    always @(posedge aclk) begin
        mlcd_pkg::result_t want;
        if (!aresetn) begin
            s_fire   <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            s_fire   <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mlcd_pkg::CFG_FIRST_MAGIC:  magic1 = cfg_data;
                    mlcd_pkg::CFG_SECOND_MAGIC: magic2 = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                void'(byte_q.pop_front());
                items_in++;
                parse_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing pending: kind %0d byte %02h idx %0d",
                        m_tuser, m_tdata[7:0], m_tdata[18:8]));
                end else begin
                    want = result_q.pop_front();
                    if (m_tuser !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, wanted %s", m_tuser, want.kind.name()));
                    end
                    if (m_tdata[7:0] !== want.data) begin
                        report_mismatch($sformatf("byte %02h, wanted %02h", m_tdata[7:0], want.data));
                    end
                    if (m_tdata[18:8] !== want.index) begin
                        report_mismatch($sformatf("index %0d, wanted %0d", m_tdata[18:8], want.index));
                    end
                    if (m_tdata[23:19] !== 5'd0) begin
                        report_mismatch($sformatf("tdata pad bits %b not zero", m_tdata[23:19]));
                    end
                end
            end
        end
    end

    // Driver: bursts of items from byte_q with random gaps between them
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold the current item until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= byte_q[0];
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: backpressure pattern, one of four modes, chosen anew at random intervals
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    int unsigned rx_period = 2;
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            rx_left   = $urandom_range(20, 300);
            rx_period = $urandom_range(2, 12);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: begin
                rx_tick = (rx_tick + 1) % rx_period;
                m_tready <= (rx_tick == 0);
            end
            default:     m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: give up after a long stretch with no handshake at all
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, result_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_pushed++;
    endtask

    // Well-formed frame with random body; bad_crc flips the check byte
    task automatic push_frame(input int unsigned len, input bit bad_crc);
        logic [15:0] l;
        logic [7:0]  b;
        logic [7:0]  crc;
        l = 16'(len);
        crc = mlcd_pkg::CRC_INIT;
        push_byte(magic1);
        push_byte(magic2);
        push_byte(l[15:8]);
        push_byte(l[7:0]);
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom);
            crc = crc8_step(crc, b);
            push_byte(b);
        end
        push_byte(bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc);
    endtask

    task automatic push_header(input logic [15:0] len);
        push_byte(magic1);
        push_byte(magic2);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endtask

    // Mostly good frames, plus bad lengths, wrong start bytes, cut frames, noise
    task automatic fill_random(input int unsigned n);
        int unsigned target;
        int unsigned sel;
        int unsigned len;
        logic [7:0]  b;
        target = bytes_pushed + n;
        while (bytes_pushed < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(17, MAX_BODY + 1)
                                                   : $urandom_range(1, 16);
                push_frame(len, $urandom_range(0, 9) == 0);
            end else if (sel < 75) begin
                case ($urandom_range(0, 2))
                    0:       push_header(16'h0000);
                    1:       push_header(16'($urandom_range(MAX_BODY + 2, 65535)));
                    default: push_header(16'hFFFF);
                endcase
            end else if (sel < 83) begin
                push_byte(magic1);
                do begin
                    b = 8'($urandom);
                end while (b == magic2);
                push_byte(b);
            end else if (sel < 90) begin
                len = $urandom_range(4, 16);
                push_header(16'(len));
                for (int unsigned i = $urandom_range(1, len); i < len; i++) begin
                    push_byte(8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
            end
        end
    endtask

    // Sender stops until all pending items and results are through
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (byte_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
        end while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_magics(input logic [7:0] first, input logic [7:0] second);
        wait_drained();
        write_reg(mlcd_pkg::CFG_FIRST_MAGIC, first);
        write_reg(mlcd_pkg::CFG_SECOND_MAGIC, second);
    endtask

    // Stimulus
    initial begin
        logic [7:0] crc;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset start bytes are both zero
        push_frame(1, 1'b0);

        set_magics(8'hA5, 8'h5A);
        // message id only, good check byte
        push_frame(1, 1'b0);
        // extreme body bytes with a wrong check byte
        crc = crc8_step(crc8_step(mlcd_pkg::CRC_INIT, 8'hFF), 8'h00);
        push_header(16'd2);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(crc ^ 8'h80);
        // wrong second start byte equal to the first: it must not restart a frame
        push_byte(8'hA5);
        push_byte(8'hA5);
        push_byte(8'h5A);
        push_byte(8'h00);
        push_byte(8'h01);
        // zero, one-past-max and all-ones lengths
        push_header(16'h0000);
        push_header(16'(MAX_BODY + 2));
        push_header(16'hFFFF);
        fill_random(250);

        set_magics(8'hFF, 8'hFF);
        push_frame(MAX_BODY + 1, 1'b0);
        fill_random(200);

        set_magics(8'h00, 8'hFF);
        fill_random(200);

        set_magics(8'($urandom), 8'($urandom));
        fill_random(250);
        push_frame(17, 1'b1);
        fill_random(100);

        wait_drained();
        repeat (8) @(negedge aclk);

        $display("Sent %0d bytes over five start-byte settings: %0d body bytes out,",
                 items_in, body_bytes);
        $display("%0d good frames, %0d CRC mismatches, %0d bad lengths, %0d mismatches",
                 frames_good, frames_crc_bad, frames_bad_len, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mlcd_pkg.sv
rtl/mlcd_core.sv
rtl/mlcd_outbuf.sv
rtl/magic_length_crc8_deframer.sv
tb/magic_length_crc8_deframer_tb.sv
